// File: design/ffba_pkg.sv
`timescale 1ns / 1ps

package ffba_pkg;

	// Block geometry: every block of the pool holds this many bytes.
	localparam int unsigned BLOCK_BYTES = 256;
	localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);

	// Width of a block count in whole blocks, enough for a request of 2^32 - 1 bytes.
	localparam int unsigned NEED_W = 33 - BLOCK_SHIFT;

	// Block counts handed to the byte conversion are at most 2^16 blocks.
	localparam int unsigned BLK_CNT_W = 17;
	localparam int unsigned BYTES_W = 21;
	localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

	localparam logic [12:0] POOL_RESET = 13'd4096;

	// Map marks.
	localparam logic [1:0] MARK_FREE = 2'd0;
	localparam logic [1:0] MARK_USED = 2'd1;
	localparam logic [1:0] MARK_LAST = 2'd2;

	// Commands.
	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FAIL = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	// Configuration register indexes.
	localparam logic REG_BASE_ADDR = 1'b0;
	localparam logic REG_POOL_BLOCKS = 1'b1;

	typedef struct packed {
		logic [1:0] cmd;
		logic [31:0] req_bytes;
		logic [31:0] address;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] alloc_addr;
		logic [BYTES_W-1:0] region_bytes;
		logic [BYTES_W-1:0] free_bytes;
	} out_item_t;

	// Configuration as seen by the sequencer.
	typedef struct packed {
		logic [31:0] base_addr;
		logic [12:0] pool_blocks;
		logic clear;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ALLOC_SCAN,
		ST_ALLOC_MARK,
		ST_RUN_SCAN,
		ST_DONE
	} state_t;

	// Blocks to bytes, saturating at the width of the byte fields.
	function automatic logic [BYTES_W-1:0] sat_bytes(input logic [BLK_CNT_W-1:0] blocks);
		logic [BLK_CNT_W+BLOCK_SHIFT-1:0] bytes;
		bytes = (BLK_CNT_W + BLOCK_SHIFT)'(blocks) << BLOCK_SHIFT;
		if (bytes > (BLK_CNT_W + BLOCK_SHIFT)'(BYTES_MAX)) begin
			sat_bytes = BYTES_MAX;
		end else begin
			sat_bytes = BYTES_W'(bytes);
		end
	endfunction

endpackage

// File: design/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// Allocate runs a first-fit scan of the map, one map entry per cycle through the map memory's
// read port, then marks each block of the run it found. Free and query walk the run from the
// addressed block; requests rejected on decode go straight to the result. One item at a time:
// the next is taken once the result sits in the output register. Reset and every pool_blocks
// write clear the map, during which no item is accepted; configuration writes are always taken.

module first_fit_block_allocator #(
	parameter int MAX_BLOCKS = 4096
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input ffba_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output ffba_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [31:0] cfg_data
);

	logic [31:0] base_q;
	logic [12:0] pool_q;
	logic cfg_fire;
	ffba_pkg::cfg_t cfg;

	logic res_valid, res_ready;
	ffba_pkg::out_item_t res_data;
	logic out_valid_q;
	ffba_pkg::out_item_t out_data_q;

	assign cfg_ready = 1'b1;
	assign cfg_fire = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			pool_q <= ffba_pkg::POOL_RESET;
		end else if (cfg_fire) begin
			case (cfg_index)
				ffba_pkg::REG_BASE_ADDR: base_q <= cfg_data;
				ffba_pkg::REG_POOL_BLOCKS: pool_q <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.base_addr = base_q;
		cfg.pool_blocks = pool_q;
		cfg.clear = cfg_fire && (cfg_index == ffba_pkg::REG_POOL_BLOCKS);
	end

	ffba_ctrl #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

	// Output register: a finished result waits here so the sequencer can move on.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_data_q <= res_data;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

// File: design/ffba_ram.sv
`timescale 1ns / 1ps

module ffba_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	input logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: design/ffba_ctrl.sv
`timescale 1ns / 1ps

module ffba_ctrl #(
	parameter int MAX_BLOCKS = 4096
) (
	input logic clk,
	input logic arst_n,
	input ffba_pkg::cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input ffba_pkg::in_item_t in_data,
	output logic res_valid,
	input logic res_ready,
	output ffba_pkg::out_item_t res_data
);

	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

	ffba_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0] n;
	logic [CNT_W-1:0] n_last;

	logic rd_en, wr_en;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	logic [1:0] wr_data, rd_data;

	logic [IDX_W-1:0] clr_ptr_q;
	logic [1:0] cmd_q;
	logic [CNT_W-1:0] need_q;
	logic [CNT_W-1:0] rd_ptr_q;
	logic pend_s1;
	logic [CNT_W-1:0] chk_idx_s1;
	logic [CNT_W-1:0] run_q;
	logic first_q;
	logic [CNT_W-1:0] wr_ptr_q, start_q, end_q;
	logic [CNT_W-1:0] free_cnt_q;
	logic [CNT_W-1:0] len_q;
	logic [1:0] status_q;
	logic [31:0] addr_q;

	logic in_fire;
	logic [ffba_pkg::NEED_W-1:0] need_full;
	logic need_ok;
	logic [31:0] offset;
	logic [31:0] idx_full;
	logic addr_ok;
	logic clr_done;
	logic at_end;
	logic [CNT_W-1:0] run_inc;
	logic alloc_free, alloc_hit, alloc_miss;
	logic walk_in_run, walk_ignore, walk_done;
	logic [CNT_W-1:0] len_new;

	ffba_ram #(
		.WIDTH(2),
		.DEPTH(MAX_BLOCKS)
	) u_marks (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Pool size in blocks, capped at the map depth.
	always_comb begin
		if (32'(cfg.pool_blocks) > 32'(MAX_BLOCKS)) begin
			n = CNT_W'(MAX_BLOCKS);
		end else begin
			n = CNT_W'(cfg.pool_blocks);
		end
		n_last = n - CNT_W'(1);
	end

	// Decode of the incoming request and of the map entry coming back from memory.
	always_comb begin
		in_fire = in_valid && in_ready;
		need_full = ffba_pkg::NEED_W'(in_data.req_bytes >> ffba_pkg::BLOCK_SHIFT)
			+ ffba_pkg::NEED_W'(|in_data.req_bytes[ffba_pkg::BLOCK_SHIFT-1:0]);
		need_ok = (need_full != '0) && (need_full <= ffba_pkg::NEED_W'(n));
		offset = in_data.address - cfg.base_addr;
		idx_full = offset >> ffba_pkg::BLOCK_SHIFT;
		addr_ok = (in_data.address >= cfg.base_addr) && (idx_full < 32'(n));
		clr_done = clr_ptr_q == IDX_W'(MAX_BLOCKS - 1);

		at_end = chk_idx_s1 == n_last;
		run_inc = run_q + CNT_W'(1);
		alloc_free = pend_s1 && (rd_data == ffba_pkg::MARK_FREE);
		alloc_hit = alloc_free && (run_inc == need_q);
		alloc_miss = pend_s1 && !alloc_hit && at_end;

		walk_in_run = pend_s1
			&& (rd_data == ffba_pkg::MARK_USED || rd_data == ffba_pkg::MARK_LAST);
		walk_ignore = pend_s1 && first_q && (rd_data == ffba_pkg::MARK_FREE);
		walk_done = pend_s1 && ((rd_data != ffba_pkg::MARK_USED) || at_end);
		len_new = walk_in_run ? len_q + CNT_W'(1) : len_q;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffba_pkg::ST_CLEAR: begin
				if (clr_done) state_d = ffba_pkg::ST_IDLE;
			end
			ffba_pkg::ST_IDLE: begin
				if (in_fire) begin
					case (in_data.cmd)
						ffba_pkg::CMD_ALLOC: begin
							state_d = need_ok ? ffba_pkg::ST_ALLOC_SCAN : ffba_pkg::ST_DONE;
						end
						ffba_pkg::CMD_FREE, ffba_pkg::CMD_QUERY: begin
							state_d = addr_ok ? ffba_pkg::ST_RUN_SCAN : ffba_pkg::ST_DONE;
						end
						default: state_d = ffba_pkg::ST_DONE;
					endcase
				end
			end
			ffba_pkg::ST_ALLOC_SCAN: begin
				if (alloc_hit) begin
					state_d = ffba_pkg::ST_ALLOC_MARK;
				end else if (alloc_miss) begin
					state_d = ffba_pkg::ST_DONE;
				end
			end
			ffba_pkg::ST_ALLOC_MARK: begin
				if (wr_ptr_q == end_q) state_d = ffba_pkg::ST_DONE;
			end
			ffba_pkg::ST_RUN_SCAN: begin
				if (walk_ignore || walk_done) state_d = ffba_pkg::ST_DONE;
			end
			ffba_pkg::ST_DONE: begin
				if (res_ready) state_d = ffba_pkg::ST_IDLE;
			end
			default: state_d = ffba_pkg::ST_CLEAR;
		endcase
		// A new pool size wipes the map whatever is going on.
		if (cfg.clear) state_d = ffba_pkg::ST_CLEAR;
	end

	// Outputs and memory port control.
	always_comb begin
		in_ready = 1'b0;
		res_valid = 1'b0;
		rd_en = 1'b0;
		rd_addr = rd_ptr_q[IDX_W-1:0];
		wr_en = 1'b0;
		wr_addr = clr_ptr_q;
		wr_data = ffba_pkg::MARK_FREE;
		case (state_q)
			ffba_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ffba_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			ffba_pkg::ST_ALLOC_SCAN: begin
				rd_en = rd_ptr_q < n;
			end
			ffba_pkg::ST_ALLOC_MARK: begin
				wr_en = 1'b1;
				wr_addr = wr_ptr_q[IDX_W-1:0];
				wr_data = (wr_ptr_q == end_q) ? ffba_pkg::MARK_LAST : ffba_pkg::MARK_USED;
			end
			ffba_pkg::ST_RUN_SCAN: begin
				rd_en = rd_ptr_q < n;
				wr_en = (cmd_q == ffba_pkg::CMD_FREE) && walk_in_run && !walk_ignore;
				wr_addr = chk_idx_s1[IDX_W-1:0];
			end
			ffba_pkg::ST_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
		res_data.status = status_q;
		res_data.alloc_addr = addr_q;
		res_data.region_bytes = ffba_pkg::sat_bytes(ffba_pkg::BLK_CNT_W'(len_q));
		res_data.free_bytes = ffba_pkg::sat_bytes(ffba_pkg::BLK_CNT_W'(free_cnt_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::ST_CLEAR;
			clr_ptr_q <= '0;
			pend_s1 <= 1'b0;
			free_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			pend_s1 <= rd_en && (state_d == state_q);
			if (cfg.clear) begin
				clr_ptr_q <= '0;
			end else if (state_q == ffba_pkg::ST_CLEAR) begin
				clr_ptr_q <= clr_ptr_q + IDX_W'(1);
				free_cnt_q <= n;
			end
			if (state_q == ffba_pkg::ST_ALLOC_MARK && wr_ptr_q == end_q) begin
				free_cnt_q <= free_cnt_q - need_q;
			end
			if (state_q == ffba_pkg::ST_RUN_SCAN && walk_done && !walk_ignore
					&& cmd_q == ffba_pkg::CMD_FREE) begin
				free_cnt_q <= free_cnt_q + len_new;
			end
		end
	end

	// Datapath registers of the current item.
	always_ff @(posedge clk) begin
		chk_idx_s1 <= rd_ptr_q;
		if (rd_en) rd_ptr_q <= rd_ptr_q + CNT_W'(1);
		case (state_q)
			ffba_pkg::ST_IDLE: begin
				if (in_fire) begin
					cmd_q <= in_data.cmd;
					need_q <= CNT_W'(need_full);
					rd_ptr_q <= (in_data.cmd == ffba_pkg::CMD_ALLOC) ? '0 : CNT_W'(idx_full);
					run_q <= '0;
					len_q <= '0;
					first_q <= 1'b1;
					addr_q <= '0;
					status_q <= (in_data.cmd == ffba_pkg::CMD_ALLOC)
						? ffba_pkg::ST_FAIL : ffba_pkg::ST_IGNORED;
				end
			end
			ffba_pkg::ST_ALLOC_SCAN: begin
				if (pend_s1) run_q <= alloc_free ? run_inc : '0;
				if (alloc_hit) begin
					start_q <= chk_idx_s1 + CNT_W'(1) - need_q;
					wr_ptr_q <= chk_idx_s1 + CNT_W'(1) - need_q;
					end_q <= chk_idx_s1;
				end
			end
			ffba_pkg::ST_ALLOC_MARK: begin
				wr_ptr_q <= wr_ptr_q + CNT_W'(1);
				addr_q <= cfg.base_addr + 32'(64'(start_q) << ffba_pkg::BLOCK_SHIFT);
				if (wr_ptr_q == end_q) status_q <= ffba_pkg::ST_OK;
			end
			ffba_pkg::ST_RUN_SCAN: begin
				if (pend_s1) first_q <= 1'b0;
				if (!walk_ignore) begin
					len_q <= len_new;
					if (walk_done) status_q <= ffba_pkg::ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

	// The walk reads one entry ahead of the one it rewrites, so the ports never meet.
	a_no_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("map read and write at the same entry");

	a_free_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ffba_pkg::ST_CLEAR) |-> (free_cnt_q <= n))
		else $error("free block count exceeds pool size");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("second item taken while one is in progress");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.status != ffba_pkg::ST_OK)
		|-> (res_data.alloc_addr == '0 && res_data.region_bytes == '0))
		else $error("failed result carries an address or size");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

// Shadow copy of the block map. Every accepted request is predicted straight away, so the
// expected response queue always holds the answers still owed by the block, oldest first.
class block_map_scoreboard;
	localparam int unsigned MAP_DEPTH = 4096;
	localparam int unsigned BLK_BYTES = 256;
	localparam longint unsigned BYTE_CAP = 2097151;

	logic [1:0] marks [MAP_DEPTH];
	logic [31:0] base;
	logic [12:0] pool;
	ffba_pkg::out_item_t expected_results [$];
	logic [31:0] live_starts [$];
	int errors;

	function new();
		base = '0;
		pool = 13'd4096;
		errors = 0;
		clear_marks();
	endfunction

	function void clear_marks();
		foreach (marks[i]) begin
			marks[i] = ffba_pkg::MARK_FREE;
		end
		live_starts.delete();
	endfunction

	function int unsigned usable_blocks();
		return (pool > MAP_DEPTH) ? MAP_DEPTH : int'(pool);
	endfunction

	function void note_config(logic idx, logic [31:0] val);
		if (idx == ffba_pkg::REG_BASE_ADDR) begin
			base = val;
			live_starts.delete();
		end else begin
			pool = val[12:0];
			clear_marks();
		end
	endfunction

	function logic [20:0] to_bytes(int unsigned blocks);
		longint unsigned b;
		b = longint'(blocks) * BLK_BYTES;
		return (b > BYTE_CAP) ? 21'(BYTE_CAP) : 21'(b);
	endfunction

	function int unsigned count_free();
		int unsigned c;
		c = 0;
		for (int unsigned i = 0; i < usable_blocks(); i++) begin
			if (marks[i] == ffba_pkg::MARK_FREE) c++;
		end
		return c;
	endfunction

	// An address selects a block only if it lies at or above the base, inside the pool,
	// and on a block that belongs to an allocation.
	function bit block_of(logic [31:0] addr, output int unsigned idx);
		idx = 0;
		if (addr < base) return 0;
		idx = int'((addr - base) >> 8);
		if (idx >= usable_blocks() || marks[idx] == ffba_pkg::MARK_FREE) return 0;
		return 1;
	endfunction

	// The run ends at its last block, at a free block or at the end of the pool.
	function int unsigned run_blocks(int unsigned idx);
		int unsigned len;
		int unsigned i;
		len = 0;
		i = idx;
		while (i < usable_blocks() && marks[i] == ffba_pkg::MARK_USED) begin
			len++;
			i++;
		end
		if (i < usable_blocks() && marks[i] == ffba_pkg::MARK_LAST) len++;
		return len;
	endfunction

	function void note_request(ffba_pkg::in_item_t req);
		ffba_pkg::out_item_t res;
		int unsigned n;
		int unsigned need;
		int unsigned run;
		int unsigned start;
		int unsigned idx;
		int unsigned len;
		n = usable_blocks();
		res = '0;
		res.status = ffba_pkg::ST_IGNORED;
		if (req.cmd == ffba_pkg::CMD_ALLOC) begin
			need = int'(req.req_bytes >> 8) + ((req.req_bytes[7:0] != 8'd0) ? 1 : 0);
			res.status = ffba_pkg::ST_FAIL;
			run = 0;
			if (need != 0 && need <= n) begin
				for (int unsigned i = 0; i < n && res.status != ffba_pkg::ST_OK; i++) begin
					if (marks[i] != ffba_pkg::MARK_FREE) begin
						run = 0;
					end else begin
						run++;
						if (run == need) begin
							start = i + 1 - need;
							for (int unsigned k = start; k < i; k++) begin
								marks[k] = ffba_pkg::MARK_USED;
							end
							marks[i] = ffba_pkg::MARK_LAST;
							res.alloc_addr = base + 32'(start * BLK_BYTES);
							res.status = ffba_pkg::ST_OK;
							live_starts.push_back(res.alloc_addr);
						end
					end
				end
			end
		end else if (req.cmd == ffba_pkg::CMD_FREE || req.cmd == ffba_pkg::CMD_QUERY) begin
			if (block_of(req.address, idx)) begin
				len = run_blocks(idx);
				if (req.cmd == ffba_pkg::CMD_FREE) begin
					for (int unsigned k = idx; k < idx + len; k++) begin
						marks[k] = ffba_pkg::MARK_FREE;
					end
				end
				res.region_bytes = to_bytes(len);
				res.status = ffba_pkg::ST_OK;
			end
		end
		res.free_bytes = to_bytes(count_free());
		expected_results.push_back(res);
	endfunction

	function int pending();
		return expected_results.size();
	endfunction

	task report(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	task check_response(ffba_pkg::out_item_t got);
		ffba_pkg::out_item_t want;
		if (expected_results.size() == 0) begin
			report($sformatf("response beat with nothing outstanding: %h", got));
		end else begin
			want = expected_results.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.alloc_addr !== want.alloc_addr)
				report($sformatf("alloc_addr %h, expected %h", got.alloc_addr, want.alloc_addr));
			if (got.region_bytes !== want.region_bytes)
				report($sformatf("region_bytes %0d, expected %0d",
					got.region_bytes, want.region_bytes));
			if (got.free_bytes !== want.free_bytes)
				report($sformatf("free_bytes %0d, expected %0d",
					got.free_bytes, want.free_bytes));
		end
	endtask
endclass

module tb_top;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 50000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	ffba_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready = 1'b0;
	ffba_pkg::out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [31:0] cfg_data;

	int send_idle_pct = 18;
	int recv_idle_pct = 61;
	int quiet_cycles = 0;
	block_map_scoreboard map_sb;

	first_fit_block_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Beats are taken in the order configuration, request, response; configuration is
	// only written while nothing is in flight, so the order never matters in practice.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) map_sb.note_config(cfg_index, cfg_data);
			if (in_valid && in_ready) map_sb.note_request(in_data);
			if (out_valid && out_ready) map_sb.check_response(out_data);
			if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic ffba_pkg::in_item_t make_item(logic [1:0] cmd, logic [31:0] req,
			logic [31:0] addr);
		ffba_pkg::in_item_t it;
		it.cmd = cmd;
		it.req_bytes = req;
		it.address = addr;
		return it;
	endfunction

	// Mostly small requests and addresses that hit live allocations, with some noise.
	function automatic ffba_pkg::in_item_t random_item();
		ffba_pkg::in_item_t it;
		int unsigned pick;
		int unsigned n;
		int unsigned nlive;
		n = map_sb.usable_blocks();
		nlive = map_sb.live_starts.size();
		it.cmd = CMD_UNUSED;
		it.req_bytes = $urandom;
		it.address = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			it.cmd = ffba_pkg::CMD_ALLOC;
			case ($urandom_range(0, 9))
				0: it.req_bytes = '0;
				1: ;
				2: it.req_bytes = 32'(n) << 8;
				3: it.req_bytes = (32'(n) << 8) + 32'd1;
				default: it.req_bytes = $urandom_range(1, 6 * 256);
			endcase
		end else if (pick < 93) begin
			it.cmd = (pick < 72) ? ffba_pkg::CMD_FREE : ffba_pkg::CMD_QUERY;
			if (nlive != 0 && $urandom_range(0, 3) != 0)
				it.address = map_sb.live_starts[$urandom_range(0, nlive - 1)]
					+ $urandom_range(0, 3 * 256);
			else if ($urandom_range(0, 1) == 1)
				it.address = map_sb.base + $urandom_range(0, (n + 2) * 256);
		end
		return it;
	endfunction

	// All driving tasks are entered and left at a falling edge.
	task automatic send_item(ffba_pkg::in_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = it;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_config(logic idx, logic [31:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (map_sb.pending() != 0) @(negedge clk);
	endtask

	task automatic run_random(int unsigned items);
		for (int unsigned i = 0; i < items; i++) begin
			send_item(random_item());
		end
		wait_drained();
	endtask

	initial begin
		map_sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset values: base 0 and a full pool of 4096 blocks.
		send_item(make_item(ffba_pkg::CMD_ALLOC, 32'd0, 32'hFFFF_FFFF));
		send_item(make_item(ffba_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'd0));
		send_item(make_item(ffba_pkg::CMD_ALLOC, 32'd1048576, 32'd0));
		send_item(make_item(ffba_pkg::CMD_ALLOC, 32'd1, 32'd0));
		send_item(make_item(ffba_pkg::CMD_QUERY, 32'd0, 32'h000F_FFFF));
		send_item(make_item(ffba_pkg::CMD_FREE, 32'd0, 32'h0000_0080));
		send_item(make_item(ffba_pkg::CMD_QUERY, 32'd0, 32'd0));
		send_item(make_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		wait_drained();

		write_config(ffba_pkg::REG_BASE_ADDR, 32'h8000_0000);
		write_config(ffba_pkg::REG_POOL_BLOCKS, 32'd8);
		send_item(make_item(ffba_pkg::CMD_ALLOC, 32'd256, 32'd0));
		send_item(make_item(ffba_pkg::CMD_ALLOC, 32'd257, 32'd0));
		send_item(make_item(ffba_pkg::CMD_ALLOC, 32'd2049, 32'd0));
		send_item(make_item(ffba_pkg::CMD_QUERY, 32'd0, 32'h7FFF_FFFF));
		send_item(make_item(ffba_pkg::CMD_QUERY, 32'd0, 32'h8000_0800));
		send_item(make_item(ffba_pkg::CMD_QUERY, 32'd0, 32'h8000_0105));
		// Freeing the second run's last block alone leaves a run without its last block behind it.
		send_item(make_item(ffba_pkg::CMD_FREE, 32'd0, 32'h8000_0200));
		send_item(make_item(ffba_pkg::CMD_QUERY, 32'd0, 32'h8000_0100));
		send_item(make_item(ffba_pkg::CMD_FREE, 32'd0, 32'hFFFF_FFFF));
		wait_drained();

		write_config(ffba_pkg::REG_POOL_BLOCKS, 32'd0);
		send_item(make_item(ffba_pkg::CMD_ALLOC, 32'd256, 32'd0));
		send_item(make_item(ffba_pkg::CMD_FREE, 32'd0, 32'h8000_0000));
		send_item(make_item(ffba_pkg::CMD_QUERY, 32'd0, 32'h8000_0000));
		wait_drained();

		// Oversized pool near the top of the address space, so the second start wraps.
		write_config(ffba_pkg::REG_BASE_ADDR, 32'hFFFF_FF00);
		write_config(ffba_pkg::REG_POOL_BLOCKS, 32'h0000_1FFF);
		send_item(make_item(ffba_pkg::CMD_ALLOC, 32'd512, 32'd0));
		send_item(make_item(ffba_pkg::CMD_ALLOC, 32'd256, 32'd0));
		send_item(make_item(ffba_pkg::CMD_QUERY, 32'd0, 32'h0000_0100));
		send_item(make_item(ffba_pkg::CMD_FREE, 32'd0, 32'hFFFF_FFFF));
		wait_drained();

		write_config(ffba_pkg::REG_BASE_ADDR, 32'h1000_0000);
		write_config(ffba_pkg::REG_POOL_BLOCKS, 32'd32);
		run_random(35);
		write_config(ffba_pkg::REG_BASE_ADDR, $urandom);
		write_config(ffba_pkg::REG_POOL_BLOCKS, 32'd4096);
		run_random(5);

		send_idle_pct = 61;
		recv_idle_pct = 18;
		write_config(ffba_pkg::REG_BASE_ADDR, 32'hFFFF_F800);
		write_config(ffba_pkg::REG_POOL_BLOCKS, 32'd20);
		run_random(35);
		write_config(ffba_pkg::REG_BASE_ADDR, $urandom);
		write_config(ffba_pkg::REG_POOL_BLOCKS, 32'h0000_1FFF);
		run_random(5);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_config(ffba_pkg::REG_BASE_ADDR, $urandom);
		// Bits above the 13-bit pool field must be dropped, leaving 48 blocks.
		write_config(ffba_pkg::REG_POOL_BLOCKS, 32'hFFFF_E030);
		run_random(36);

		repeat (32) @(posedge clk);
		if (map_sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

// File: first_fit_block_allocator.f
design/ffba_pkg.sv
design/ffba_ram.sv
design/ffba_ctrl.sv
design/first_fit_block_allocator.sv
tb/tb_top.sv
